// ===== hw/rtl/uet_pkg.sv =====
// Shared types and constants for the undirected edge table.
`default_nettype none

package uet_pkg;

  localparam int unsigned VERTEX_W     = 6;
  localparam int unsigned WEIGHT_W     = 32;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned EDGE_TOTAL_W = 9;
  localparam int unsigned CAP_W        = 9;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Register index, taken from paddr above the byte offset
  localparam logic [0:0] REG_EDGE_CAPACITY = 1'b0;

  // Operation codes; code three means nothing
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 3'd0,
    STATUS_FULL    = 3'd1,
    STATUS_SELF    = 3'd2,
    STATUS_DUP     = 3'd3,
    STATUS_MISSING = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [VERTEX_W-1:0] va;
    logic [VERTEX_W-1:0] vb;
    logic [WEIGHT_W-1:0] w;
  } edge_t;

  // Per-cycle command to every cell of the row
  typedef struct packed {
    logic rotate;  // take the right neighbor
    logic push;    // take the left neighbor
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uet_if.sv =====
// Valid/ready channel interfaces for operation and result transactions.
`default_nettype none

interface uet_in_if;
  import uet_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [VERTEX_W-1:0] vertex_a;
  logic [VERTEX_W-1:0] vertex_b;
  logic [WEIGHT_W-1:0] weight_in;

  modport source (output valid, mode, vertex_a, vertex_b, weight_in, input ready);
  modport sink   (input valid, mode, vertex_a, vertex_b, weight_in, output ready);
endinterface

interface uet_out_if;
  import uet_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [WEIGHT_W-1:0]     weight_out;
  logic [EDGE_TOTAL_W-1:0] edge_total;

  modport source (output valid, status, weight_out, edge_total, input ready);
  modport sink   (input valid, status, weight_out, edge_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/uet_cell.sv =====
// One storage cell of the edge row: holds one entry and shifts either way.
`default_nettype none

module uet_cell import uet_pkg::*; (
  input  wire logic      clk_i,
  input  wire cell_ctl_t ctl_i,
  input  wire edge_t     left_i,
  input  wire edge_t     right_i,
  output edge_t          entry_o
);

  edge_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.rotate) begin
      entry_d = right_i;
    end else if (ctl_i.push) begin
      entry_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== hw/rtl/uet_cfg.sv =====
// APB configuration register block holding the edge capacity.
`default_nettype none

module uet_cfg import uet_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [CAP_W-1:0]   cap_o
);

  logic [CAP_W-1:0] cap_q, cap_d;
  logic             hit;

  assign hit    = (paddr[PADDR_W-1:2] == REG_EDGE_CAPACITY);
  assign pready = 1'b1;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && hit) begin
      cap_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = hit ? PDATA_W'(cap_q) : '0;
  assign cap_o  = cap_q;

endmodule

`default_nettype wire

// ===== hw/rtl/undirected_edge_table_unit.sv =====
// Undirected weighted edge table built as a rotating row of storage cells.
//
//   channel   dir  handshake        payload
//   in_i      in   valid/ready      mode, vertex_a, vertex_b, weight_in
//   out_o     out  valid/ready      status, weight_out, edge_total
//   apb       in   psel/penable     paddr, pwdata -> prdata (edge_capacity)
//
// An operation is taken in S_IDLE, then makes one full turn of the cell row
// past the head comparator in S_SCAN, one push or pop step in S_SHIFT for an
// add or remove that changes the table, and loads the output register in
// S_DONE before S_IDLE takes the next transaction.
// Reset clears the edge count, the control state and the output valid.
// A result that is not taken holds the next operation in its final cycle;
// a new transaction is taken while the previous result still waits.
`default_nettype none

module undirected_edge_table_unit import uet_pkg::*; #(
  parameter int unsigned MaxEdges = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  uet_in_if.sink                  in_i,
  uet_out_if.source               out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  // Count runs 0..MaxEdges; the comparison with the capacity uses the wider
  localparam int unsigned CntW = $clog2(MaxEdges + 1);
  localparam int unsigned CmpW = (CntW > CAP_W) ? CntW : CAP_W;
  localparam logic [CntW-1:0] LastStep = CntW'(MaxEdges - 1);
  localparam logic [CntW-1:0] Depth    = CntW'(MaxEdges);

  logic [CAP_W-1:0] cap;

  uet_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  // ---------------------------------------------------------------------
  // Control and operation registers
  // ---------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [CntW-1:0]         step_q, step_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [MODE_W-1:0]       mode_q, mode_d;
  edge_t                   op_q, op_d;       // operand pair and new weight
  edge_t                   hold_q, hold_d;   // top entry, fills a removed slot
  logic                    found_q, found_d;
  logic [WEIGHT_W-1:0]     wout_q, wout_d;
  status_e                 status_q, status_d;

  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q, out_status_d;
  logic [WEIGHT_W-1:0]     out_weight_q, out_weight_d;
  logic [EDGE_TOTAL_W-1:0] out_total_q, out_total_d;

  // ---------------------------------------------------------------------
  // Cell row. Slots 0..count-1 are live, the newest entry sits in slot 0.
  // Rotation moves every cell one place toward the head; the head value
  // (or the held top entry when a remove hits) re-enters at the tail, so
  // a full turn through all MaxEdges cells puts every entry back where it was.
  // ---------------------------------------------------------------------
  edge_t     cells [MaxEdges];
  edge_t     head;
  edge_t     feed;
  cell_ctl_t ctl;
  logic      match;
  logic      full;
  logic      found_any;

  for (genvar i = 0; i < MaxEdges; i++) begin : g_cell
    edge_t left_in, right_in;
    if (i == 0) begin : g_first
      assign left_in = op_q;
    end else begin : g_mid_left
      assign left_in = cells[i-1];
    end
    if (i == MaxEdges - 1) begin : g_last
      assign right_in = feed;
    end else begin : g_mid_right
      assign right_in = cells[i+1];
    end

    uet_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left_in),
      .right_i (right_in),
      .entry_o (cells[i])
    );
  end

  assign head = cells[0];

  // Head comparator: the pair matches either way round
  assign match = (step_q < count_q) &&
                 (((head.va == op_q.va) && (head.vb == op_q.vb)) ||
                  ((head.va == op_q.vb) && (head.vb == op_q.va)));

  // Swap-remove: the matching slot takes the top entry captured at step 0
  assign feed = ((mode_q == MODE_REMOVE) && match && (step_q != '0)) ? hold_q : head;

  assign full = (CmpW'(count_q) >= CmpW'(cap)) || (count_q == Depth);
  assign found_any = found_q || match;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    count_d      = count_q;
    mode_d       = mode_q;
    op_d         = op_q;
    hold_d       = hold_q;
    found_d      = found_q;
    wout_d       = wout_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_weight_d = out_weight_q;
    out_total_d  = out_total_q;
    ctl          = '0;
    in_i.ready   = 1'b0;

    // Drop the result once taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          mode_d  = in_i.mode;
          op_d.va = in_i.vertex_a;
          op_d.vb = in_i.vertex_b;
          op_d.w  = in_i.weight_in;
          step_d  = '0;
          found_d = 1'b0;
          wout_d  = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        ctl.rotate = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == '0) begin
          hold_d = head;
        end
        if (match) begin
          found_d = 1'b1;
          wout_d  = head.w;
        end
        if (step_q == LastStep) begin
          state_d = S_DONE;
          unique case (mode_q)
            MODE_ADD: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else if (op_q.va == op_q.vb) begin
                status_d = STATUS_SELF;
              end else if (found_any) begin
                status_d = STATUS_DUP;
              end else begin
                status_d = STATUS_OK;
                state_d  = S_SHIFT;
              end
            end
            MODE_REMOVE: begin
              status_d = found_any ? STATUS_OK : STATUS_MISSING;
              if (found_any) begin
                state_d = S_SHIFT;
              end
            end
            MODE_LOOKUP: begin
              status_d = found_any ? STATUS_OK : STATUS_MISSING;
            end
            default: begin
              status_d = STATUS_MISSING;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Push the new edge into the head, or pop the old top off it
        if (mode_q == MODE_ADD) begin
          ctl.push = 1'b1;
          count_d  = count_q + 1'b1;
        end else begin
          ctl.rotate = 1'b1;
          count_d    = count_q - 1'b1;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_weight_d = ((mode_q == MODE_LOOKUP) && (status_q == STATUS_OK)) ? wout_q : '0;
          out_total_d  = EDGE_TOTAL_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    op_q         <= op_d;
    hold_q       <= hold_d;
    found_q      <= found_d;
    wout_q       <= wout_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_weight_q <= out_weight_d;
    out_total_q  <= out_total_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.weight_out = out_weight_q;
  assign out_o.edge_total = out_total_q;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the undirected edge table unit.

module tb;
  import uet_pkg::*;

  localparam int unsigned EDGE_SLOTS = 256;
  // The package names no code for the spare mode value
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD = 1200;
  localparam int unsigned SETTLE_CYCLES = 300;

  typedef struct packed {
    status_e                 status;
    logic [WEIGHT_W-1:0]     weight;
    logic [EDGE_TOTAL_W-1:0] total;
  } edge_result_t;

  // Mirror of the edge table: applies each accepted operation and keeps the
  // results it predicts until the block returns them.
  class edge_table_mirror;
    logic [VERTEX_W-1:0] va [EDGE_SLOTS];
    logic [VERTEX_W-1:0] vb [EDGE_SLOTS];
    logic [WEIGHT_W-1:0] wt [EDGE_SLOTS];
    int unsigned         count;
    logic [CAP_W-1:0]    capacity;
    edge_result_t        awaited [$];
    int                  failures;

    function new();
      count    = 0;
      capacity = CAP_RESET;
      failures = 0;
    endfunction

    // Slot of the pair in either order, or -1 when absent
    function int find_pair(logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
      for (int i = 0; i < int'(count); i++) begin
        if ((va[i] == a && vb[i] == b) || (va[i] == b && vb[i] == a)) return i;
      end
      return -1;
    endfunction

    function void take_op(logic [MODE_W-1:0] mode, logic [VERTEX_W-1:0] a,
                          logic [VERTEX_W-1:0] b, logic [WEIGHT_W-1:0] w);
      edge_result_t r;
      int           slot;
      int unsigned  lim;
      r.status = STATUS_MISSING;
      r.weight = '0;
      lim = (capacity > EDGE_SLOTS) ? EDGE_SLOTS : capacity;
      case (mode)
        MODE_ADD: begin
          if (count >= lim) r.status = STATUS_FULL;
          else if (a == b) r.status = STATUS_SELF;
          else if (find_pair(a, b) >= 0) r.status = STATUS_DUP;
          else begin
            va[count] = a;
            vb[count] = b;
            wt[count] = w;
            count++;
            r.status = STATUS_OK;
          end
        end
        MODE_REMOVE: begin
          slot = find_pair(a, b);
          if (slot >= 0) begin
            va[slot] = va[count-1];
            vb[slot] = vb[count-1];
            wt[slot] = wt[count-1];
            count--;
            r.status = STATUS_OK;
          end
        end
        MODE_LOOKUP: begin
          slot = find_pair(a, b);
          if (slot >= 0) begin
            r.weight = wt[slot];
            r.status = STATUS_OK;
          end
        end
        default: ;
      endcase
      r.total = EDGE_TOTAL_W'(count);
      awaited.push_back(r);
    endfunction

    function void compare_result(logic [STATUS_W-1:0] status, logic [WEIGHT_W-1:0] weight,
                                 logic [EDGE_TOTAL_W-1:0] total);
      edge_result_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d, weight_out %0h, edge_total %0d",
               status, weight, total);
        failures++;
        return;
      end
      e = awaited.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        failures++;
      end
      if (weight !== e.weight) begin
        $error("weight_out: expected %0h, actual %0h", e.weight, weight);
        failures++;
      end
      if (total !== e.total) begin
        $error("edge_total: expected %0d, actual %0d", e.total, total);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  uet_in_if  in_ch ();
  uet_out_if out_ch ();

  edge_table_mirror mirror;

  // Shared pacing controls: calm suppresses random idling on both sides,
  // stall_request asks the result side for one long hold-off.
  bit calm          = 1'b0;
  bit stall_request = 1'b0;

  undirected_edge_table_unit #(
    .MaxEdges(EDGE_SLOTS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Gap length for random idling: mostly short, sometimes long enough to
  // land anywhere inside one full scan of the table.
  function automatic int unsigned gap_len();
    return ($urandom_range(3) == 0) ? $urandom_range(270, 1) : $urandom_range(4, 1);
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one operation, hold it until the block takes it, then record the
  // transaction and optionally drop valid for a random gap.
  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [VERTEX_W-1:0] a,
                         input logic [VERTEX_W-1:0] b, input logic [WEIGHT_W-1:0] w);
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.vertex_a  <= a;
    in_ch.vertex_b  <= b;
    in_ch.weight_in <= w;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    mirror.take_op(mode, a, b, w);
    if (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (mirror.awaited.size() != 0);
  endtask

  // Write edge_capacity through setup and access phases, then read it back.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_EDGE_CAPACITY, 2'b00});
    pwdata  <= PDATA_W'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    mirror.capacity = cap;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[CAP_W-1:0] !== cap) begin
      $error("edge_capacity: expected %0d, actual %0d", cap, prdata[CAP_W-1:0]);
      mirror.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Build one random operation. Removes and lookups mostly target stored
  // edges (either orientation) so the table really churns; the remainder
  // after add/remove/lookup shares is noise: spare mode, self loops, junk.
  task automatic issue_random_op(input int unsigned add_pct, input int unsigned rem_pct,
                                 input int unsigned look_pct, input int unsigned pool);
    int unsigned         pick;
    int unsigned         slot;
    logic [MODE_W-1:0]   mode;
    logic [VERTEX_W-1:0] a;
    logic [VERTEX_W-1:0] b;
    logic [VERTEX_W-1:0] tmp;
    pick = $urandom_range(99);
    a = VERTEX_W'($urandom_range(pool));
    b = VERTEX_W'($urandom_range(pool));
    if (pick < add_pct) begin
      mode = MODE_ADD;
    end else if (pick < add_pct + rem_pct + look_pct) begin
      mode = (pick < add_pct + rem_pct) ? MODE_REMOVE : MODE_LOOKUP;
      if (mirror.count > 0 && $urandom_range(9) < 8) begin
        slot = $urandom_range(mirror.count - 1);
        a = mirror.va[slot];
        b = mirror.vb[slot];
        if ($urandom_range(1) == 1) begin
          tmp = a;
          a   = b;
          b   = tmp;
        end
      end
    end else begin
      case ($urandom_range(2))
        0: mode = MODE_UNUSED;
        1: begin
          mode = ($urandom_range(2) == 0) ? MODE_ADD :
                 ($urandom_range(1) == 0) ? MODE_REMOVE : MODE_LOOKUP;
          b = a;
        end
        default: begin
          mode = MODE_W'($urandom_range(3));
          a = VERTEX_W'($urandom_range(63));
          b = VERTEX_W'($urandom_range(63));
        end
      endcase
    end
    send_op(mode, a, b, rand_weight());
  endtask

  // One capacity setting with its own operation mix. The stressed phase
  // adds a long result-side hold-off, a stretch without idling and a full
  // pause of the operation side.
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned n,
                           input int unsigned add_pct, input int unsigned rem_pct,
                           input int unsigned look_pct, input int unsigned pool,
                           input bit stress);
    drain_results();
    repeat (4) @(posedge clk_i);
    write_capacity(cap);
    for (int unsigned i = 0; i < n; i++) begin
      if (stress) begin
        if (i == 40) stall_request = 1'b1;
        if (i == 120) calm = 1'b1;
        if (i == 220) calm = 1'b0;
        if (i == 250) drain_results();
      end
      issue_random_op(add_pct, rem_pct, look_pct, pool);
    end
  endtask

  // Check every result transaction at the edge where it is taken.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      mirror.compare_result(out_ch.status, out_ch.weight_out, out_ch.edge_total);
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request,
  // counted here so the operation side keeps offering meanwhile.
  initial begin
    int unsigned hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        hold = LONG_HOLD;
      end else if (hold == 0 && !calm && $urandom_range(99) < 11) begin
        hold = 1;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_ADD;
    in_ch.vertex_a  <= '0;
    in_ch.vertex_b  <= '0;
    in_ch.weight_in <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    mirror = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk with a tiny capacity: empty table, both orientations,
    // check order of full before self loop and full before duplicate, swap-remove,
    // self-loop remove/lookup, spare mode, extreme vertices and weights.
    write_capacity(9'd3);
    send_op(MODE_LOOKUP,  6'd1,  6'd2,  32'h0000_0000);
    send_op(MODE_REMOVE,  6'd1,  6'd2,  32'hFFFF_FFFF);
    send_op(MODE_ADD,     6'd0,  6'd63, 32'hFFFF_FFFF);
    send_op(MODE_ADD,     6'd63, 6'd0,  32'h1234_5678);
    send_op(MODE_ADD,     6'd0,  6'd63, 32'h0000_0001);
    send_op(MODE_ADD,     6'd5,  6'd5,  32'h8000_0000);
    send_op(MODE_LOOKUP,  6'd63, 6'd0,  32'h0000_0000);
    send_op(MODE_ADD,     6'd1,  6'd2,  32'h0000_0000);
    send_op(MODE_LOOKUP,  6'd2,  6'd1,  32'hFFFF_FFFF);
    send_op(MODE_ADD,     6'd3,  6'd4,  32'hA5A5_5A5A);
    send_op(MODE_ADD,     6'd7,  6'd8,  32'h0F0F_0F0F);
    send_op(MODE_ADD,     6'd9,  6'd9,  32'h0F0F_0F0F);
    send_op(MODE_ADD,     6'd3,  6'd4,  32'h0F0F_0F0F);
    send_op(MODE_REMOVE,  6'd9,  6'd9,  32'h0000_0000);
    send_op(MODE_LOOKUP,  6'd9,  6'd9,  32'h0000_0000);
    send_op(MODE_UNUSED,  6'd3,  6'd4,  32'hFFFF_FFFF);
    send_op(MODE_REMOVE,  6'd0,  6'd63, 32'h0000_0000);
    send_op(MODE_LOOKUP,  6'd4,  6'd3,  32'h0000_0000);
    send_op(MODE_LOOKUP,  6'd0,  6'd63, 32'h0000_0000);
    send_op(MODE_ADD,     6'd63, 6'd62, 32'h1234_5678);
    send_op(MODE_REMOVE,  6'd2,  6'd1,  32'h0000_0000);
    send_op(MODE_REMOVE,  6'd62, 6'd63, 32'h0000_0000);
    send_op(MODE_REMOVE,  6'd3,  6'd4,  32'h0000_0000);
    send_op(MODE_REMOVE,  6'd3,  6'd4,  32'h0000_0000);
    send_op(MODE_UNUSED,  6'd63, 6'd63, 32'h0000_0000);

    // Fill to the full table with the register above the table size, churn
    // at exactly the table size, shrink it with capacity zero, then small
    // capacities with a narrow vertex pool so duplicates are common.
    run_phase(9'd511, 380, 85,  5,  5, 63, 1'b0);
    run_phase(9'd256, 300, 40, 25, 25, 63, 1'b1);
    run_phase(9'd0,   200, 15, 65, 15, 63, 1'b0);
    run_phase(CAP_W'($urandom_range(40, 2)), 400, 40, 30, 25, 11, 1'b0);
    run_phase(9'd1,   120, 40, 30, 25,  5, 1'b0);
    run_phase(9'd256, 100, 40, 30, 25, 63, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mirror.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/uet_pkg.sv
hw/rtl/uet_if.sv
hw/rtl/uet_cell.sv
hw/rtl/uet_cfg.sv
hw/rtl/undirected_edge_table_unit.sv
bench/tb.sv
